// ===== hw/rtl/cavr_pkg.sv =====
package cavr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MIN      = 8;

  localparam int SH_W  = 64 - FRAC_MIN;
  localparam int POS_W = SH_W + 2;

  localparam int QBITS      = 41;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (QBITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_LAST   = QBITS - DIV_STEPS * (DIV_STAGES - 1);

  localparam logic [QBITS-1:0] Q_CAP = QBITS'(1) << (QBITS - 1);

  localparam logic [30:0] MAX_SPEED_RST = 31'h7fff_ffff;
  localparam logic [30:0] ACCEL_RST     = 31'd65536;

  typedef enum logic {
    REG_MAX_SPEED = 1'b0,
    REG_ACCEL     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0]     x0;
    logic signed [31:0]     v0c;
    logic signed [31:0]     v1c;
    logic                   neg;
    logic                   nz;
    logic                   ramp;
    logic [31:0]            dv;
    logic signed [SH_W-1:0] v0t;
    logic signed [SH_W-1:0] v1t;
    logic [SH_W-1:0]        half;
  } cavr_ctx_t;

  typedef struct packed {
    logic             vld;
    cavr_ctx_t        ctx;
    logic             ovf;
    logic [31:0]      rem;
    logic [QBITS-1:0] num;
    logic [QBITS-1:0] quo;
  } cavr_div_t;

  function automatic logic signed [31:0] clamp_vel(logic signed [31:0] v, logic [30:0] lim);
    logic signed [32:0] l;
    logic signed [32:0] v33;
    l   = $signed({2'b00, lim});
    v33 = $signed({v[31], v});
    if (v33 > l) begin
      clamp_vel = l[31:0];
    end else if (v33 < -l) begin
      clamp_vel = 32'(-l);
    end else begin
      clamp_vel = v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [POS_W-1:0] x);
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo;
    hi = POS_W'(32'sh7fff_ffff);
    lo = -hi - POS_W'(1);
    if (x > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/cavr_item_if.sv =====
interface cavr_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_pos;
  logic signed [31:0] start_vel;
  logic signed [31:0] target_vel;
  logic [30:0]        elapsed;

  modport source(output valid, start_pos, start_vel, target_vel, elapsed, input ready);
  modport sink(input valid, start_pos, start_vel, target_vel, elapsed, output ready);
endinterface

// ===== hw/rtl/cavr_result_if.sv =====
interface cavr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_out;
  logic signed [31:0] vel_out;

  modport source(output valid, pos_out, vel_out, input ready);
  modport sink(input valid, pos_out, vel_out, output ready);
endinterface

// ===== hw/rtl/cavr_cfg_if.sv =====
interface cavr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [30:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cavr_front.sv =====
module cavr_front #(
  parameter int FRAC_BITS = cavr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [31:0]  start_pos,
  input  logic signed [31:0]  start_vel,
  input  logic signed [31:0]  target_vel,
  input  logic [30:0]         elapsed,
  input  logic [30:0]         max_speed,
  input  logic [30:0]         accel,
  output cavr_pkg::cavr_div_t beat
);
  import cavr_pkg::*;

  // s1: clamp
  logic               s1_vld;
  logic signed [31:0] s1_x0, s1_v0, s1_v1;
  logic [30:0]        s1_t;
  // s2: difference and products
  logic               s2_vld;
  logic signed [31:0] s2_x0, s2_v0, s2_v1;
  logic [30:0]        s2_t;
  logic signed [32:0] s2_d;
  logic [61:0]        s2_ta;
  logic signed [63:0] s2_v0t, s2_v1t;
  // s3: ramp test
  logic               s3_vld;
  logic signed [31:0] s3_x0, s3_v0, s3_v1;
  logic [30:0]        s3_t;
  logic [31:0]        s3_ad;
  logic               s3_neg, s3_nz, s3_ramp;
  logic [31:0]        s3_dv;
  logic signed [SH_W-1:0] s3_v0t, s3_v1t;
  // s4: square and area
  logic               s4_vld;
  cavr_ctx_t          s4_ctx;
  logic [63:0]        s4_sq;

  logic signed [31:0] t_s;
  logic [32:0]        d_abs;
  logic [31:0]        ad;
  logic [62:0]        hp;
  logic [31:0]        dvsr;
  logic [63-QBITS:0]  sq_hi;

  assign t_s   = $signed({1'b0, s1_t});
  assign d_abs = s2_d[32] ? 33'(-s2_d) : 33'(s2_d);
  assign ad    = d_abs[31:0];
  assign hp    = 63'(s3_dv) * 63'(s3_t);
  assign dvsr  = {accel, 1'b0};
  assign sq_hi = s4_sq[63:QBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      s4_vld   <= 1'b0;
      beat.vld <= 1'b0;
    end else if (en) begin
      s1_vld   <= in_vld;
      s2_vld   <= s1_vld;
      s3_vld   <= s2_vld;
      s4_vld   <= s3_vld;
      beat.vld <= s4_vld;
    end
    if (en) begin
      s1_x0 <= start_pos;
      s1_v0 <= clamp_vel(start_vel, max_speed);
      s1_v1 <= clamp_vel(target_vel, max_speed);
      s1_t  <= elapsed;

      s2_x0  <= s1_x0;
      s2_v0  <= s1_v0;
      s2_v1  <= s1_v1;
      s2_t   <= s1_t;
      s2_d   <= 33'(s1_v1) - 33'(s1_v0);
      s2_ta  <= 62'(s1_t) * 62'(accel);
      s2_v0t <= 64'(s1_v0) * 64'(t_s);
      s2_v1t <= 64'(s1_v1) * 64'(t_s);

      s3_x0   <= s2_x0;
      s3_v0   <= s2_v0;
      s3_v1   <= s2_v1;
      s3_t    <= s2_t;
      s3_ad   <= ad;
      s3_neg  <= s2_d[32];
      s3_nz   <= |s2_d;
      s3_ramp <= s2_ta <= (62'(ad) << FRAC_BITS);
      s3_dv   <= 32'(s2_ta >> FRAC_BITS);
      s3_v0t  <= SH_W'(s2_v0t >>> FRAC_BITS);
      s3_v1t  <= SH_W'(s2_v1t >>> FRAC_BITS);

      s4_ctx.x0   <= s3_x0;
      s4_ctx.v0c  <= s3_v0;
      s4_ctx.v1c  <= s3_v1;
      s4_ctx.neg  <= s3_neg;
      s4_ctx.nz   <= s3_nz;
      s4_ctx.ramp <= s3_ramp;
      s4_ctx.dv   <= s3_dv;
      s4_ctx.v0t  <= s3_v0t;
      s4_ctx.v1t  <= s3_v1t;
      s4_ctx.half <= SH_W'(hp >> (FRAC_BITS + 1));
      s4_sq       <= 64'(s3_ad) * 64'(s3_ad);

      // quotient above 41 bits is flagged and capped later
      beat.ctx <= s4_ctx;
      beat.ovf <= 32'(sq_hi) >= dvsr;
      beat.rem <= (32'(sq_hi) >= dvsr) ? 32'd0 : 32'(sq_hi);
      beat.num <= s4_sq[QBITS-1:0];
      beat.quo <= '0;
    end
  end

endmodule

// ===== hw/rtl/cavr_div_stage.sv =====
module cavr_div_stage #(
  parameter int STEPS = cavr_pkg::DIV_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [30:0]         accel,
  input  cavr_pkg::cavr_div_t din,
  output cavr_pkg::cavr_div_t dout
);
  import cavr_pkg::*;

  logic [31:0]      dvsr;
  logic [31:0]      r;
  logic [32:0]      r33;
  logic [QBITS-1:0] n;
  logic [QBITS-1:0] q;

  assign dvsr = {accel, 1'b0};

  always_comb begin
    r = din.rem;
    n = din.num;
    q = din.quo;
    r33 = '0;
    for (int k = 0; k < STEPS; k++) begin
      r33 = {r, n[QBITS-1]};
      n   = n << 1;
      if (r33 >= {1'b0, dvsr}) begin
        r = 32'(r33 - {1'b0, dvsr});
        q = {q[QBITS-2:0], 1'b1};
      end else begin
        r = r33[31:0];
        q = {q[QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.ctx <= din.ctx;
      dout.ovf <= din.ovf;
      dout.rem <= r;
      dout.num <= n;
      dout.quo <= q;
    end
  end

endmodule

// ===== hw/rtl/cavr_back.sv =====
module cavr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cavr_pkg::cavr_div_t din,
  output logic                out_vld,
  output logic signed [31:0]  pos_out,
  output logic signed [31:0]  vel_out
);
  import cavr_pkg::*;

  logic                    e1_vld;
  logic signed [31:0]      e1_x0;
  logic signed [POS_W-1:0] e1_vsh, e1_term;
  logic signed [33:0]      e1_vel;
  logic                    e2_vld;
  logic signed [POS_W-1:0] e2_pos;
  logic signed [33:0]      e2_vel;

  logic [QBITS-1:0]        qf;
  logic signed [POS_W-1:0] qv, hv, term, vsh;
  logic signed [33:0]      dv34, vel;
  cavr_ctx_t               c;

  assign c    = din.ctx;
  assign qf   = (din.ovf || din.quo > Q_CAP) ? Q_CAP : din.quo;
  assign qv   = $signed(POS_W'(qf));
  assign hv   = $signed(POS_W'(c.half));
  assign dv34 = $signed({2'b00, c.dv});

  always_comb begin
    if (!c.nz) begin
      term = '0;
    end else if (c.ramp) begin
      term = c.neg ? -hv : hv;
    end else begin
      term = c.neg ? qv : -qv;
    end
    vsh = c.ramp ? POS_W'(c.v0t) : POS_W'(c.v1t);
    if (!c.ramp) begin
      vel = 34'(c.v1c);
    end else if (!c.nz) begin
      vel = 34'(c.v0c);
    end else begin
      vel = 34'(c.v0c) + (c.neg ? -dv34 : dv34);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld  <= 1'b0;
      e2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      e1_vld  <= din.vld;
      e2_vld  <= e1_vld;
      out_vld <= e2_vld;
    end
    if (en) begin
      e1_x0   <= c.x0;
      e1_vsh  <= vsh;
      e1_term <= term;
      e1_vel  <= vel;
      e2_pos  <= POS_W'(e1_x0) + e1_vsh + e1_term;
      e2_vel  <= e1_vel;
      pos_out <= sat32(e2_pos);
      vel_out <= sat32(POS_W'(e2_vel));
    end
  end

endmodule

// ===== hw/rtl/constant_accel_velocity_ramp.sv =====
// Velocity ramp evaluator: each beat on item gives start position, start and target
// velocity and elapsed time (signed Q16.16, time unsigned) and yields one beat on result
// with the position and velocity at that time, saturated to 32 bits. The block is a
// fixed pipeline taking one beat per clock; its depth is set by the 11-stage divider
// that forms the cruise offset (4 quotient bits per stage, 1 in the last) after
// five stages of clamping and multiplication and before three stages of summing and
// saturation. A stall on result holds the whole pipeline. Write max_speed (index 0) and
// accel_rate (index 1) on cfg only while no beat is in flight; an accel_rate of zero is
// stored as one LSB.
module constant_accel_velocity_ramp #(
  parameter int FRAC_BITS = cavr_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cavr_item_if.sink     item,
  cavr_result_if.source result,
  cavr_cfg_if.sink      cfg
);
  import cavr_pkg::*;

  logic        en;
  logic [30:0] max_speed;
  logic [30:0] accel;
  cavr_div_t   chain [DIV_STAGES+1];

  assign en         = !result.valid || result.ready;
  assign item.ready = en;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_SPEED_RST;
      accel     <= ACCEL_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_SPEED: max_speed <= cfg.data;
        REG_ACCEL:     accel <= (cfg.data == '0) ? 31'd1 : cfg.data;
        default:       ;
      endcase
    end
  end

  cavr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (item.valid),
    .start_pos  (item.start_pos),
    .start_vel  (item.start_vel),
    .target_vel (item.target_vel),
    .elapsed    (item.elapsed),
    .max_speed  (max_speed),
    .accel      (accel),
    .beat       (chain[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    cavr_div_stage #(
      .STEPS((i == DIV_STAGES - 1) ? DIV_LAST : DIV_STEPS)
    ) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .accel (accel),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  cavr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .din     (chain[DIV_STAGES]),
    .out_vld (result.valid),
    .pos_out (result.pos_out),
    .vel_out (result.vel_out)
  );

endmodule

// ===== hw/rtl/cavr_checker.sv =====
module cavr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_out,
  input logic [31:0] vel_out
);

  logic [5:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 6'(in_valid && in_ready) - 6'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pos_out) && $stable(vel_out))
    else $error("result payload changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 6'd0)
    else $error("result beat without an accepted item");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while pipeline stalled");

endmodule

bind constant_accel_velocity_ramp cavr_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .pos_out   (result.pos_out),
  .vel_out   (result.vel_out)
);
